// ===== hw/rtl/dlg_pkg.sv =====
package dlg_pkg;

   localparam int unsigned LEN_W    = 16;
   localparam int unsigned DEMAND_W = 11;
   localparam int unsigned NUM_W    = 6;

   typedef struct packed {
      logic load;
      logic idx_clr;
      logic idx_inc;
      logic insert;
      logic hit_wr;
      logic clear;
   } dlg_cmd_type;

   typedef struct packed {
      logic at_end;
      logic hit;
      logic last_item;
      logic final_type;
   } dlg_status_type;

endpackage

// ===== hw/rtl/dlg_req_if.sv =====
interface dlg_req_if;
   import dlg_pkg::*;

   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] item_length;
   logic             last_item;

   modport source (output valid, output item_length, output last_item, input ready);
   modport sink (input valid, input item_length, input last_item, output ready);

endinterface

// ===== hw/rtl/dlg_rsp_if.sv =====
interface dlg_rsp_if;
   import dlg_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEN_W-1:0]    type_length;
   logic [DEMAND_W-1:0] type_demand;
   logic [NUM_W-1:0]    type_number;
   logic                last_type;
   logic                overflowed;

   modport source (
      output valid, output type_length, output type_demand, output type_number,
      output last_type, output overflowed, input ready
   );
   modport sink (
      input valid, input type_length, input type_demand, input type_number,
      input last_type, input overflowed, output ready
   );

endinterface

// ===== hw/rtl/distinct_length_grouper.sv =====
// Groups item lengths into types in order of first appearance and counts them.
// The req channel carries one item per transaction: item_length and last_item.
// The rsp channel carries one type per transaction: type_length, type_demand,
// type_number, last_type and overflowed.
// An accepted item is compared against the stored types one entry per cycle
// through the table; the next item can be accepted only once the search ends,
// at the matching type or, for a new length, after all stored types. The search
// is the limit. On an item with last_item set, a table fetch state follows the
// search and then one type is presented per cycle while rsp.ready is high.
// No item is accepted during output.
// When rsp.ready is low, the current type holds on the channel unchanged.
// After the final type is taken, the table and overflow flag are empty again.
// Reset is synchronous; it empties the table, clears the overflow flag and
// returns the block to accepting items. Table contents need no clearing.
module distinct_length_grouper #(
   parameter int unsigned MAX_TYPES  = 32,
   parameter int unsigned COUNT_BITS = 11
) (
   input  logic       clock,
   input  logic       reset,
   dlg_req_if.sink    req,
   dlg_rsp_if.source  rsp
);
   import dlg_pkg::*;

   dlg_cmd_type    cmd;
   dlg_status_type status;

   dlg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dlg_datapath #(
      .MAX_TYPES  (MAX_TYPES),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .item_length (req.item_length),
      .last_item   (req.last_item),
      .cmd         (cmd),
      .status      (status),
      .type_length (rsp.type_length),
      .type_demand (rsp.type_demand),
      .type_number (rsp.type_number),
      .last_type   (rsp.last_type),
      .overflowed  (rsp.overflowed)
   );

endmodule

// ===== hw/rtl/dlg_ctrl.sv =====
module dlg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dlg_pkg::dlg_status_type status,
   output dlg_pkg::dlg_cmd_type    cmd
);
   import dlg_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.at_end || status.hit) begin
               cmd.insert  = status.at_end;
               cmd.hit_wr  = !status.at_end;
               cmd.idx_clr = 1'b1;
               state_in    = status.last_item ? ST_FETCH : ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.final_type) begin
                  cmd.clear   = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/dlg_datapath.sv =====
module dlg_datapath #(
   parameter int unsigned MAX_TYPES  = 32,
   parameter int unsigned COUNT_BITS = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [dlg_pkg::LEN_W-1:0]    item_length,
   input  logic                         last_item,
   input  dlg_pkg::dlg_cmd_type         cmd,
   output dlg_pkg::dlg_status_type      status,
   output logic [dlg_pkg::LEN_W-1:0]    type_length,
   output logic [dlg_pkg::DEMAND_W-1:0] type_demand,
   output logic [dlg_pkg::NUM_W-1:0]    type_number,
   output logic                         last_type,
   output logic                         overflowed
);
   import dlg_pkg::*;

   localparam int unsigned AW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
   localparam int unsigned IW = $clog2(MAX_TYPES + 1);

   logic [LEN_W-1:0]      len_mem [MAX_TYPES];
   logic [COUNT_BITS-1:0] cnt_mem [MAX_TYPES];

   logic [LEN_W-1:0]      item_len_ff;
   logic                  item_last_ff;
   logic [IW-1:0]         idx_ff;
   logic [IW-1:0]         idx_in;
   logic [IW-1:0]         used_ff;
   logic                  ovf_ff;
   logic [LEN_W-1:0]      rd_len_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;

   logic [IW-1:0]              idx_next;
   logic                       full;
   logic [COUNT_BITS-1:0]      cnt_inc;
   logic [IW+NUM_W-1:0]        num_ext;
   logic [COUNT_BITS+DEMAND_W-1:0] cnt_ext;

   assign idx_next = idx_ff + IW'(1);
   assign full     = (used_ff == IW'(MAX_TYPES));
   assign cnt_inc  = (&rd_cnt_ff) ? rd_cnt_ff : rd_cnt_ff + COUNT_BITS'(1);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         used_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.clear) begin
            used_ff <= '0;
            ovf_ff  <= 1'b0;
         end else if (cmd.insert) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               used_ff <= used_ff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_len_ff  <= item_length;
         item_last_ff <= last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert && !full) begin
         len_mem[idx_ff[AW-1:0]] <= item_len_ff;
         cnt_mem[idx_ff[AW-1:0]] <= COUNT_BITS'(1);
      end else if (cmd.hit_wr) begin
         cnt_mem[idx_ff[AW-1:0]] <= cnt_inc;
      end
      rd_len_ff <= len_mem[idx_in[AW-1:0]];
      rd_cnt_ff <= cnt_mem[idx_in[AW-1:0]];
   end

   assign status.at_end     = (idx_ff == used_ff);
   assign status.hit        = (rd_len_ff == item_len_ff);
   assign status.last_item  = item_last_ff;
   assign status.final_type = (idx_next == used_ff);

   assign num_ext = {{NUM_W{1'b0}}, idx_next};
   assign cnt_ext = {{DEMAND_W{1'b0}}, rd_cnt_ff};

   assign type_length = rd_len_ff;
   assign type_demand = cnt_ext[DEMAND_W-1:0];
   assign type_number = num_ext[NUM_W-1:0];
   assign last_type   = status.final_type;
   assign overflowed  = ovf_ff;

endmodule

// ===== hw/rtl/dlg_checker.sv =====
module dlg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dlg_pkg::LEN_W-1:0]    type_length,
   input logic [dlg_pkg::DEMAND_W-1:0] type_demand,
   input logic [dlg_pkg::NUM_W-1:0]    type_number,
   input logic                         last_type
);
   import dlg_pkg::*;

   a_no_accept_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted while types are being sent");

   a_first_type_is_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> type_number == NUM_W'(1))
      else $error("output set does not start at type one");

   a_number_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_type |=>
         rsp_valid && type_number == NUM_W'($past(type_number) + NUM_W'(1)))
      else $error("type numbers not consecutive within a set");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(type_length) && $stable(type_demand)
         && $stable(type_number) && $stable(last_type))
      else $error("stalled transaction changed");

endmodule

bind distinct_length_grouper dlg_checker u_dlg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .type_length (rsp.type_length),
   .type_demand (rsp.type_demand),
   .type_number (rsp.type_number),
   .last_type   (rsp.last_type)
);

// ===== test/grouping_check_pkg.sv =====
`timescale 1ns / 1ps

package grouping_check_pkg;
   import dlg_pkg::*;

   localparam int unsigned GROUP_TABLE_DEPTH = 32;
   localparam int unsigned GROUP_COUNT_BITS  = 11;
   localparam int unsigned GROUP_COUNT_TOP   = (1 << GROUP_COUNT_BITS) - 1;

   typedef struct packed {
      logic [LEN_W-1:0]    length;
      logic [DEMAND_W-1:0] demand;
      logic [NUM_W-1:0]    number;
      logic                last;
      logic                overflow;
   } type_result_type;

   class grouping_scoreboard;
      logic [LEN_W-1:0] lengths[GROUP_TABLE_DEPTH];
      int unsigned      demands[GROUP_TABLE_DEPTH];
      int unsigned      types_held;
      bit               overflow_seen;
      type_result_type  expected_types[$];
      int unsigned      errors;

      function new();
         types_held    = 0;
         overflow_seen = 0;
         errors        = 0;
      endfunction

      // A transaction on the request side is grouped first; a last item then
      // releases every type of the set in order of first appearance.
      function void note_item(logic [LEN_W-1:0] len, logic last_item);
         bit              found;
         type_result_type entry;
         found = 0;
         for (int unsigned i = 0; i < types_held; i++) begin
            if (!found && lengths[i] == len) begin
               found = 1;
               if (demands[i] < GROUP_COUNT_TOP) begin
                  demands[i]++;
               end
            end
         end
         if (!found) begin
            if (types_held < GROUP_TABLE_DEPTH) begin
               lengths[types_held] = len;
               demands[types_held] = 1;
               types_held++;
            end else begin
               overflow_seen = 1;
            end
         end
         if (last_item) begin
            for (int unsigned i = 0; i < types_held; i++) begin
               entry.length   = lengths[i];
               entry.demand   = DEMAND_W'(demands[i]);
               entry.number   = NUM_W'(i + 1);
               entry.last     = (i + 1 == types_held);
               entry.overflow = overflow_seen;
               expected_types.insert(expected_types.size(), entry);
            end
            types_held    = 0;
            overflow_seen = 0;
         end
      endfunction

      function void check_type(type_result_type got);
         type_result_type want;
         if (expected_types.size() == 0) begin
            errors++;
            $display("%0t: unexpected type result len=%h demand=%0d num=%0d last=%b ovf=%b",
                     $time, got.length, got.demand, got.number, got.last, got.overflow);
            return;
         end
         want = expected_types.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: expected len=%h demand=%0d num=%0d last=%b ovf=%b",
                     $time, want.length, want.demand, want.number, want.last, want.overflow);
            $display("%0t:   actual len=%h demand=%0d num=%0d last=%b ovf=%b",
                     $time, got.length, got.demand, got.number, got.last, got.overflow);
         end
      endfunction

      function int unsigned pending();
         return expected_types.size();
      endfunction
   endclass

endpackage

// ===== test/distinct_length_grouper_test.sv =====
`timescale 1ns / 1ps

module distinct_length_grouper_test;
   import dlg_pkg::*;
   import grouping_check_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 5000;
   localparam int unsigned PHASE_ITEMS  = 80;
   localparam int unsigned SETTLE_TICKS = 50;

   typedef enum int unsigned {SET_POOLED, SET_SCATTERED, SET_OVERFLOW} set_kind_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   int unsigned        idle_pct = 0;
   int unsigned        stall_pct = 0;
   int unsigned        quiet_cycles = 0;
   int unsigned        items_sent = 0;
   grouping_scoreboard sb;

   dlg_req_if req_ch ();
   dlg_rsp_if rsp_ch ();

   distinct_length_grouper dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      type_result_type got;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         got.length   = rsp_ch.type_length;
         got.demand   = rsp_ch.type_demand;
         got.number   = rsp_ch.type_number;
         got.last     = rsp_ch.last_type;
         got.overflow = rsp_ch.overflowed;
         sb.check_type(got);
      end
      if (reset || (req_ch.valid && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("distinct_length_grouper_test: done, errors");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_item(input logic [LEN_W-1:0] len, input logic last_item);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.item_length <= len;
      req_ch.last_item   <= last_item;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      sb.note_item(len, last_item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_types();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_set(input set_kind_type kind);
      logic [LEN_W-1:0] pool[8];
      logic [LEN_W-1:0] base;
      int unsigned      count;
      int unsigned      pool_size;
      int unsigned      distinct;
      int unsigned      target;
      case (kind)
         SET_POOLED: begin
            count     = $urandom_range(12, 1);
            pool_size = $urandom_range(8, 1);
            foreach (pool[i]) begin
               pool[i] = LEN_W'($urandom);
            end
            for (int unsigned k = 0; k < count; k++) begin
               send_item(pool[$urandom_range(pool_size - 1, 0)], k == count - 1);
            end
         end
         SET_SCATTERED: begin
            count = $urandom_range(40, 1);
            for (int unsigned k = 0; k < count; k++) begin
               send_item(LEN_W'($urandom), k == count - 1);
            end
         end
         default: begin
            // The table fills or comes one short; lengths beyond it are dropped.
            base     = LEN_W'($urandom);
            target   = $urandom_range(GROUP_TABLE_DEPTH + 8, GROUP_TABLE_DEPTH - 1);
            distinct = 0;
            while (distinct < target) begin
               if (distinct > 0 && $urandom_range(3, 0) == 0) begin
                  send_item(base + LEN_W'($urandom_range(distinct - 1, 0)), 1'b0);
               end else begin
                  send_item(base + LEN_W'(distinct), 1'b0);
                  distinct++;
               end
            end
            if ($urandom_range(1, 0) == 1) begin
               send_item(base + LEN_W'(distinct), 1'b1);
            end else begin
               send_item(base + LEN_W'($urandom_range(distinct - 1, 0)), 1'b1);
            end
         end
      endcase
   endtask

   initial begin
      int unsigned idle_plan[4];
      int unsigned stall_plan[4];
      int unsigned phase_start;
      int unsigned pick;
      idle_plan  = '{0, 60, 0, 19};
      stall_plan = '{0, 0, 60, 19};
      sb = new();
      req_ch.valid       = 1'b0;
      req_ch.item_length = '0;
      req_ch.last_item   = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(16'h0000, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h5555, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'hAAAA, 1'b0);
      send_item(16'h5555, 1'b1);
      send_item(16'h8000, 1'b0);
      send_item(16'h0001, 1'b0);
      send_item(16'h7FFF, 1'b1);
      run_set(SET_OVERFLOW);

      // One length repeated many times within a set.
      send_item(16'hFFFE, 1'b0);
      repeat (12) send_item(16'h0042, 1'b0);
      send_item(16'h0042, 1'b1);

      for (int unsigned phase = 0; phase < 4; phase++) begin
         drain_types();
         idle_pct    = idle_plan[phase];
         stall_pct   = stall_plan[phase];
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(9, 0);
            if (pick < 5) begin
               run_set(SET_POOLED);
            end else if (pick < 8) begin
               run_set(SET_SCATTERED);
            end else begin
               run_set(SET_OVERFLOW);
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("distinct_length_grouper_test: done, clean");
      end else begin
         $display("distinct_length_grouper_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dlg_pkg.sv
hw/rtl/dlg_req_if.sv
hw/rtl/dlg_rsp_if.sv
hw/rtl/dlg_ctrl.sv
hw/rtl/dlg_datapath.sv
hw/rtl/distinct_length_grouper.sv
hw/rtl/dlg_checker.sv
test/grouping_check_pkg.sv
test/distinct_length_grouper_test.sv
